@@ design/b64d_pkg.sv @@
// Shared types, constants and helpers for the base64 packet deframer.
package b64d_pkg;

  localparam int REPLAY_DEPTH_DEF   = 64;
  localparam int PAYLOAD_DEPTH_DEF  = 32;
  localparam int LENGTH_BYTES_DEF   = 2;
  localparam int PIPE_BYTES_DEF     = 1;
  localparam int CHECKSUM_BYTES_DEF = 4;

  localparam logic [1:0] REG_HEADER_WORD = 2'd0;
  localparam logic [1:0] REG_HEADER_LEN  = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

  localparam logic [1:0] KIND_PASS  = 2'd0;
  localparam logic [1:0] KIND_BODY  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_PAD = 8'h3D;

  typedef enum logic [2:0] {
    MODE_HUNT,
    MODE_LEN,
    MODE_PIPE,
    MODE_BODY,
    MODE_CKSUM
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DEC,
    PH_FL_RD,
    PH_FL_WR,
    PH_EM_RD,
    PH_EM_WR,
    PH_EMPTY
  } phase_t;

  typedef struct packed {
    logic do_byte;
    logic do_dec;
    logic ptr_clr;
    logic ld_replay;
    logic ld_body;
    logic ld_empty;
  } dp_cmd_t;

  typedef struct packed {
    logic byte_flush;
    logic byte_decode;
    logic dec_flush;
    logic dec_emit;
    logic dec_more;
    logic blen_zero;
    logic last_replay;
    logic last_body;
    logic out_free;
  } dp_status_t;

  // {valid, 6-bit value}; pad maps to zero
  function automatic logic [6:0] b64_decode(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) r = {1'b1, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    else if (c == 8'h2B) r = {1'b1, 6'd62};
    else if (c == 8'h2F) r = {1'b1, 6'd63};
    else if (c == CH_PAD) r = {1'b1, 6'd0};
    return r;
  endfunction

endpackage

@@ design/b64d_ifs.sv @@
// Stream, result and configuration channel interfaces.
interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface b64d_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data;
  logic [7:0] pipe;
  logic [5:0] packet_len;
  logic       last;
  modport source (output valid, output kind, output data, output pipe,
                  output packet_len, output last, input ready);
  modport sink   (input valid, input kind, input data, input pipe,
                  input packet_len, input last, output ready);
endinterface

interface b64d_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] value;
  modport source (output valid, output index, output value, input ready);
  modport sink   (input valid, input index, input value, output ready);
endinterface

@@ design/b64d_datapath.sv @@
// Datapath: config registers, decode state, replay and body stores, output register.
module b64d_datapath #(
  parameter int REPLAY_DEPTH   = b64d_pkg::REPLAY_DEPTH_DEF,
  parameter int PAYLOAD_DEPTH  = b64d_pkg::PAYLOAD_DEPTH_DEF,
  parameter int LENGTH_BYTES   = b64d_pkg::LENGTH_BYTES_DEF,
  parameter int PIPE_BYTES     = b64d_pkg::PIPE_BYTES_DEF,
  parameter int CHECKSUM_BYTES = b64d_pkg::CHECKSUM_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           in_byte,
  input  b64d_pkg::dp_cmd_t    cmd,
  output b64d_pkg::dp_status_t st,
  b64d_cfg_if.sink             cfg,
  b64d_result_if.source        result
);

  localparam int RCW = $clog2(REPLAY_DEPTH);
  localparam int BW  = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int PW  = (RCW > 6) ? RCW : 6;
  localparam logic [31:0] CK_MASK = 32'hFFFF_FFFF >> (8 * (4 - CHECKSUM_BYTES));

  logic [63:0] header_word;
  logic [3:0]  header_len;
  logic [5:0]  max_payload;

  b64d_pkg::mode_t mode;
  logic [5:0]  step_count;
  logic [5:0]  qval [3];
  logic [2:0]  qpad;
  logic [1:0]  quantum_count;
  logic [7:0]  qbytes [3];
  logic [1:0]  qcnt;
  logic [1:0]  k;
  logic [15:0] body_length;
  logic [7:0]  pipe_number;
  logic [31:0] sum_calc;
  logic [31:0] sum_received;
  logic [RCW-1:0] replay_count;
  logic        skip_newline;
  logic [PW-1:0] rd_ptr;

  logic [7:0] replay_mem [REPLAY_DEPTH];
  logic [7:0] body_mem [PAYLOAD_DEPTH];
  logic [7:0] replay_q;
  logic [7:0] body_q;

  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_data;
  logic [7:0] out_pipe;
  logic [5:0] out_len;
  logic       out_last;

  // byte-level decisions
  logic [6:0] dec;
  logic       is_nl, is_ws, skip_hit, hdr_match, hdr_done, quantum_full, push_ok;
  logic [3:0] hl;
  logic [7:0] hc;
  logic [5:0] step_inc;
  logic [23:0] qv;
  logic [1:0] cnt_now;
  logic       pad_now;

  assign dec      = b64d_pkg::b64_decode(in_byte);
  assign is_nl    = (in_byte == b64d_pkg::CH_LF) || (in_byte == b64d_pkg::CH_CR);
  assign is_ws    = is_nl || (in_byte == b64d_pkg::CH_SP) || (in_byte == b64d_pkg::CH_TAB);
  assign skip_hit = skip_newline && is_nl;
  assign hl       = (header_len == 4'd0) ? 4'd1 : ((header_len > 4'd8) ? 4'd8 : header_len);
  assign hc       = header_word[8*step_count[2:0] +: 8];
  assign hdr_match = (in_byte == hc);
  assign step_inc = step_count + 6'd1;
  assign hdr_done = ({2'b00, hl} <= step_inc);
  assign quantum_full = (quantum_count == 2'd3);
  assign push_ok  = ({1'b0, replay_count} + 1'b1) < (RCW+1)'(REPLAY_DEPTH);
  assign pad_now  = (in_byte == b64d_pkg::CH_PAD);
  assign qv       = {qval[0], qval[1], qval[2], dec[5:0]};

  always_comb begin
    if (qpad[0] || qpad[1]) cnt_now = 2'd0;
    else if (qpad[2])       cnt_now = 2'd1;
    else if (pad_now)       cnt_now = 2'd2;
    else                    cnt_now = 2'd3;
  end

  // decoded-byte step
  logic [7:0]  b;
  logic [15:0] blen_shift;
  logic [31:0] rx_shift;
  logic [5:0]  limit;
  b64d_pkg::mode_t mode_after;
  logic        dflush, demit;

  assign b          = qbytes[k];
  assign blen_shift = {body_length[7:0], b};
  assign rx_shift   = {sum_received[23:0], b};
  assign limit      = ({26'd0, max_payload} > PAYLOAD_DEPTH) ? 6'(PAYLOAD_DEPTH) : max_payload;

  always_comb begin
    mode_after = mode;
    dflush = 1'b0;
    demit  = 1'b0;
    case (mode)
      b64d_pkg::MODE_LEN: begin
        if (32'(step_inc) >= LENGTH_BYTES) begin
          if (blen_shift > {10'd0, limit}) begin
            mode_after = b64d_pkg::MODE_HUNT;
            dflush = 1'b1;
          end else begin
            mode_after = b64d_pkg::MODE_PIPE;
          end
        end
      end
      b64d_pkg::MODE_PIPE: begin
        if (32'(step_inc) >= PIPE_BYTES)
          mode_after = (body_length == 16'd0) ? b64d_pkg::MODE_CKSUM : b64d_pkg::MODE_BODY;
      end
      b64d_pkg::MODE_BODY: begin
        if ({10'd0, step_inc} >= body_length) mode_after = b64d_pkg::MODE_CKSUM;
      end
      b64d_pkg::MODE_CKSUM: begin
        if (32'(step_inc) >= CHECKSUM_BYTES) begin
          mode_after = b64d_pkg::MODE_HUNT;
          if ((rx_shift & CK_MASK) != (sum_calc & CK_MASK)) dflush = 1'b1;
          else demit = 1'b1;
        end
      end
      default: mode_after = mode;
    endcase
  end

  assign st.byte_flush  = !skip_hit && ((mode == b64d_pkg::MODE_HUNT) ? !hdr_match
                                        : (!dec[6] && !is_ws));
  assign st.byte_decode = !skip_hit && (mode != b64d_pkg::MODE_HUNT) && dec[6]
                          && quantum_full && (cnt_now != 2'd0);
  assign st.dec_flush   = dflush;
  assign st.dec_emit    = demit;
  assign st.dec_more    = ((k + 2'd1) < qcnt) && (mode_after != b64d_pkg::MODE_HUNT);
  assign st.blen_zero   = (body_length == 16'd0);
  assign st.last_replay = ({{(PW-RCW){1'b0}}, replay_count} == rd_ptr + 1'b1);
  assign st.last_body   = ({{(16-PW){1'b0}}, rd_ptr} + 16'd1 == body_length);
  assign st.out_free    = !out_valid || result.ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_word <= '0;
      header_len  <= 4'd1;
      max_payload <= 6'd32;
    end else if (cfg.valid) begin
      case (cfg.index)
        b64d_pkg::REG_HEADER_WORD: header_word <= cfg.value;
        b64d_pkg::REG_HEADER_LEN:  header_len  <= cfg.value[3:0];
        b64d_pkg::REG_MAX_PAYLOAD: max_payload <= cfg.value[5:0];
        default: ;
      endcase
    end
  end

  // replay and body stores, registered reads
  always_ff @(posedge clk) begin
    if (cmd.do_byte && !skip_hit && push_ok) replay_mem[replay_count] <= in_byte;
    if (cmd.do_dec && mode == b64d_pkg::MODE_BODY) body_mem[step_count[BW-1:0]] <= b;
    replay_q <= replay_mem[rd_ptr[RCW-1:0]];
    body_q   <= body_mem[rd_ptr[BW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.do_byte && !skip_hit && mode != b64d_pkg::MODE_HUNT && dec[6]) begin
      if (!quantum_full) begin
        qval[quantum_count] <= dec[5:0];
        qpad[quantum_count] <= pad_now;
      end else begin
        qbytes[0] <= qv[23:16];
        qbytes[1] <= qv[15:8];
        qbytes[2] <= qv[7:0];
        qcnt      <= cnt_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= b64d_pkg::MODE_HUNT;
      step_count    <= '0;
      quantum_count <= '0;
      body_length   <= '0;
      pipe_number   <= '0;
      sum_calc      <= '0;
      sum_received  <= '0;
      replay_count  <= '0;
      skip_newline  <= 1'b0;
      k             <= '0;
      rd_ptr        <= '0;
    end else begin
      if (cmd.do_byte) begin
        k <= '0;
        if (skip_hit) begin
          skip_newline <= 1'b0;
        end else begin
          skip_newline <= 1'b0;
          if (push_ok) replay_count <= replay_count + 1'b1;
          if (mode == b64d_pkg::MODE_HUNT) begin
            if (!hdr_match) begin
              step_count <= '0;
            end else if (hdr_done) begin
              mode          <= b64d_pkg::MODE_LEN;
              step_count    <= '0;
              quantum_count <= '0;
              body_length   <= '0;
            end else begin
              step_count <= step_inc;
            end
          end else if (dec[6]) begin
            quantum_count <= quantum_count + 2'd1;
          end else if (!is_ws) begin
            mode       <= b64d_pkg::MODE_HUNT;
            step_count <= '0;
          end
        end
      end
      if (cmd.do_dec) begin
        k    <= k + 2'd1;
        mode <= mode_after;
        step_count <= (mode_after != mode) ? 6'd0 : step_inc;
        case (mode)
          b64d_pkg::MODE_LEN: begin
            body_length <= blen_shift;
            if (mode_after == b64d_pkg::MODE_PIPE) pipe_number <= '0;
          end
          b64d_pkg::MODE_PIPE: begin
            pipe_number <= b;
            if (mode_after != mode) begin
              sum_calc     <= '0;
              sum_received <= '0;
            end
          end
          b64d_pkg::MODE_BODY: begin
            sum_calc <= sum_calc + {24'd0, b};
            if (mode_after != mode) sum_received <= '0;
          end
          b64d_pkg::MODE_CKSUM: begin
            sum_received <= rx_shift;
            if (demit) begin
              replay_count <= '0;
              skip_newline <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.ptr_clr) rd_ptr <= '0;
      if (cmd.ld_replay || cmd.ld_body) rd_ptr <= rd_ptr + 1'b1;
      if (cmd.ld_replay && st.last_replay) replay_count <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_replay || cmd.ld_body || cmd.ld_empty) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_replay) begin
      out_kind <= b64d_pkg::KIND_PASS;
      out_data <= replay_q;
      out_pipe <= '0;
      out_len  <= '0;
      out_last <= st.last_replay;
    end else if (cmd.ld_body) begin
      out_kind <= b64d_pkg::KIND_BODY;
      out_data <= body_q;
      out_pipe <= pipe_number;
      out_len  <= body_length[5:0];
      out_last <= st.last_body;
    end else if (cmd.ld_empty) begin
      out_kind <= b64d_pkg::KIND_EMPTY;
      out_data <= '0;
      out_pipe <= pipe_number;
      out_len  <= '0;
      out_last <= 1'b1;
    end
  end

  assign result.valid      = out_valid;
  assign result.kind       = out_kind;
  assign result.data       = out_data;
  assign result.pipe       = out_pipe;
  assign result.packet_len = out_len;
  assign result.last       = out_last;

  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    (mode == b64d_pkg::MODE_BODY) |-> (body_length != 16'd0))
    else $error("body mode with zero length");
  a_body_index: assert property (@(posedge clk) disable iff (rst)
    (mode == b64d_pkg::MODE_BODY) |-> (32'(step_count) < PAYLOAD_DEPTH))
    else $error("body index past store");
  a_skip_nopush: assert property (@(posedge clk) disable iff (rst)
    (cmd.do_byte && skip_hit) |=> $stable(replay_count))
    else $error("skipped newline entered replay");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.ld_replay || cmd.ld_body || cmd.ld_empty) |-> st.out_free)
    else $error("output overwritten");

endmodule

@@ design/b64d_ctrl.sv @@
// Controller: sequences byte intake, decoded-byte steps and result bursts.
module b64d_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  b64d_pkg::dp_status_t st,
  output b64d_pkg::dp_cmd_t    cmd
);

  b64d_pkg::phase_t phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) phase <= b64d_pkg::PH_IDLE;
    else     phase <= phase_next;
  end

  always_comb begin
    phase_next = phase;
    cmd        = '0;
    in_ready   = 1'b0;
    case (phase)
      b64d_pkg::PH_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.do_byte = 1'b1;
          if (st.byte_flush) begin
            cmd.ptr_clr = 1'b1;
            phase_next  = b64d_pkg::PH_FL_RD;
          end else if (st.byte_decode) begin
            phase_next = b64d_pkg::PH_DEC;
          end
        end
      end
      b64d_pkg::PH_DEC: begin
        cmd.do_dec = 1'b1;
        if (st.dec_flush) begin
          cmd.ptr_clr = 1'b1;
          phase_next  = b64d_pkg::PH_FL_RD;
        end else if (st.dec_emit) begin
          cmd.ptr_clr = 1'b1;
          phase_next  = st.blen_zero ? b64d_pkg::PH_EMPTY : b64d_pkg::PH_EM_RD;
        end else if (!st.dec_more) begin
          phase_next = b64d_pkg::PH_IDLE;
        end
      end
      b64d_pkg::PH_FL_RD: phase_next = b64d_pkg::PH_FL_WR;
      b64d_pkg::PH_FL_WR: begin
        if (st.out_free) begin
          cmd.ld_replay = 1'b1;
          phase_next = st.last_replay ? b64d_pkg::PH_IDLE : b64d_pkg::PH_FL_RD;
        end
      end
      b64d_pkg::PH_EM_RD: phase_next = b64d_pkg::PH_EM_WR;
      b64d_pkg::PH_EM_WR: begin
        if (st.out_free) begin
          cmd.ld_body = 1'b1;
          phase_next = st.last_body ? b64d_pkg::PH_IDLE : b64d_pkg::PH_EM_RD;
        end
      end
      b64d_pkg::PH_EMPTY: begin
        if (st.out_free) begin
          cmd.ld_empty = 1'b1;
          phase_next   = b64d_pkg::PH_IDLE;
        end
      end
      default: phase_next = b64d_pkg::PH_IDLE;
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_byte, cmd.do_dec, cmd.ld_replay, cmd.ld_body, cmd.ld_empty}))
    else $error("conflicting datapath commands");
  a_dec_follow: assert property (@(posedge clk) disable iff (rst)
    (phase == b64d_pkg::PH_DEC) |-> ($past(phase) == b64d_pkg::PH_DEC
                                     || $past(phase) == b64d_pkg::PH_IDLE))
    else $error("decode entered from burst");
  a_rd_then_wr: assert property (@(posedge clk) disable iff (rst)
    (phase == b64d_pkg::PH_FL_RD) |=> (phase == b64d_pkg::PH_FL_WR))
    else $error("replay read not followed by load");

endmodule

@@ design/base64_packet_deframer.sv @@
// Top level of the base64 packet deframer.
//  channel  dir  beat
//  stream   in   in_byte: one raw byte
//  result   out  kind, data, pipe, packet_len, last
//  cfg      in   index, value: register write, always ready
// A byte is taken while idle; a completed quantum then yields up to 3 decoded bytes, one at a time.
// A replay or body burst reads each result from its registered store, then loads it.
// Input is held off during a burst; result stalls hold the burst in place.
// Reset (rst, synchronous) returns to header hunt; stores need no clearing.
module base64_packet_deframer #(
  parameter int REPLAY_DEPTH   = b64d_pkg::REPLAY_DEPTH_DEF,
  parameter int PAYLOAD_DEPTH  = b64d_pkg::PAYLOAD_DEPTH_DEF,
  parameter int LENGTH_BYTES   = b64d_pkg::LENGTH_BYTES_DEF,
  parameter int PIPE_BYTES     = b64d_pkg::PIPE_BYTES_DEF,
  parameter int CHECKSUM_BYTES = b64d_pkg::CHECKSUM_BYTES_DEF
) (
  input logic           clk,
  input logic           rst,
  b64d_byte_if.sink     stream,
  b64d_result_if.source result,
  b64d_cfg_if.sink      cfg
);

  b64d_pkg::dp_cmd_t    cmd;
  b64d_pkg::dp_status_t st;

  b64d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_ready (stream.ready),
    .st       (st),
    .cmd      (cmd)
  );

  b64d_datapath #(
    .REPLAY_DEPTH   (REPLAY_DEPTH),
    .PAYLOAD_DEPTH  (PAYLOAD_DEPTH),
    .LENGTH_BYTES   (LENGTH_BYTES),
    .PIPE_BYTES     (PIPE_BYTES),
    .CHECKSUM_BYTES (CHECKSUM_BYTES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_byte (stream.in_byte),
    .cmd     (cmd),
    .st      (st),
    .cfg     (cfg),
    .result  (result)
  );

endmodule
